// ----- src/lwpc_pkg.sv -----
// Shared widths, codes and helpers for the latency window PTS compensator.
`default_nettype none
package lwpc_pkg;

  localparam int DEF_WINDOW = 32;

  localparam int LAT_W     = 24;
  localparam int TS_W      = 48;
  localparam int QUEUE_W   = 16;
  localparam int FUNC_W    = 3;
  localparam int REASON_W  = 2;
  localparam int COUNT_W   = 11;
  localparam int CTR_W     = 32;
  localparam int THR_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 24;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_COMP_COUNT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMP_VALUE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DRIFT      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_AGGRESSIVE = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;

  // Drop reason codes.
  localparam logic [REASON_W-1:0] REASON_NONE  = 2'd0;
  localparam logic [REASON_W-1:0] REASON_DRIFT = 2'd1;
  localparam logic [REASON_W-1:0] REASON_QUEUE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_PRESENT  = 1'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 24'd100000;

  typedef logic [CTR_W-1:0] ctr_t;

  // Saturating increment of an event counter.
  function automatic ctr_t sat_inc(input ctr_t c);
    return (c == '1) ? c : c + ctr_t'(1);
  endfunction

endpackage
`default_nettype wire

// ----- src/lwpc_if.sv -----
// Request and result channel interfaces of the compensator.
`default_nettype none
interface lwpc_in_if;
  import lwpc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [LAT_W-1:0]          latency_us;
  logic signed [TS_W-1:0]    pts_us;
  logic signed [TS_W-1:0]    master_clock_us;
  logic [QUEUE_W-1:0]        queue_depth;
  logic [QUEUE_W-1:0]        queue_capacity;

  modport source (output valid, func, latency_us, pts_us, master_clock_us,
                  queue_depth, queue_capacity, input ready);
  modport sink (input valid, func, latency_us, pts_us, master_clock_us,
                queue_depth, queue_capacity, output ready);
endinterface

interface lwpc_out_if;
  import lwpc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TS_W-1:0]    result_pts_us;
  logic                      drop;
  logic [REASON_W-1:0]       drop_reason;
  logic [LAT_W-1:0]          average_latency_us;
  logic [COUNT_W-1:0]        sample_count;
  logic [CTR_W-1:0]          dropped_total;
  logic [CTR_W-1:0]          compensated_total;
  logic [CTR_W-1:0]          aggressive_total;

  modport source (output valid, result_pts_us, drop, drop_reason, average_latency_us,
                  sample_count, dropped_total, compensated_total, aggressive_total,
                  input ready);
  modport sink (input valid, result_pts_us, drop, drop_reason, average_latency_us,
                sample_count, dropped_total, compensated_total, aggressive_total,
                output ready);
endinterface
`default_nettype wire

// ----- src/latency_window_pts_compensator_core.sv -----
// Top level of the latency window PTS compensator.
//
// Requests enter on in_ch (valid/ready); each one yields exactly one result
// on out_ch, in request order. A request is taken when valid and ready are
// both high at a rising edge of clk. The configuration port (cfg_we, cfg_idx,
// cfg_data) writes the drift threshold (index 0) or the clock-present flag
// (index 1) in the cycle cfg_we is high; it is meant to be used while idle.
//
// The block works on one request at a time. A request is latched at
// acceptance, evaluated in the update state and passed to the output
// register from the final state. A latency sample also passes through the
// divide state between those two, where the new window average is computed
// by a restoring divider that produces one quotient bit per cycle over the
// SUM_W-bit running sum.
//
// A result sits in an output register, so the next request is accepted while
// a finished result still waits. If the receiver stalls and a second result
// is ready, that result waits in the final state and in_ch.ready stays low.
// Synchronous reset (rst_n low) empties the window, zeroes the counters and
// the average, restores the configuration defaults and drops any result.
`default_nettype none
module latency_window_pts_compensator_core #(
  parameter int WINDOW = lwpc_pkg::DEF_WINDOW
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lwpc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [lwpc_pkg::CFG_DAT_W-1:0] cfg_data,
  lwpc_in_if.sink                             in_ch,
  lwpc_out_if.source                          out_ch
);
  import lwpc_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = LAT_W + CNT_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic signed [TS_W:0] MIN48_X = {1'b1, 1'b1, {(TS_W-1){1'b0}}};

  logic [1:0]            state_r;

  // Configuration registers.
  logic [THR_W-1:0]      thr_r;
  logic                  clk_present_r;

  // Window state.
  logic [SLOT_W-1:0]     slot_r;
  logic [CNT_W-1:0]      fill_r;
  logic [SUM_W-1:0]      sum_r;
  logic [LAT_W-1:0]      avg_r;
  ctr_t                  drift_ctr_r;
  ctr_t                  comp_ctr_r;
  ctr_t                  queue_ctr_r;

  // Sample ring memory with a registered read port.
  logic [LAT_W-1:0]      ring_mem [WINDOW];
  logic [LAT_W-1:0]      rd_data_r;

  // Latched request.
  logic [FUNC_W-1:0]     func_r;
  logic [LAT_W-1:0]      lat_r;
  logic signed [TS_W-1:0] pts_r;
  logic signed [TS_W-1:0] master_r;
  logic [QUEUE_W-1:0]    depth_r;
  logic [QUEUE_W-1:0]    cap_r;

  // Per-request result before it moves to the output register.
  logic signed [TS_W-1:0] res_pts_r;
  logic                  res_drop_r;
  logic [REASON_W-1:0]   res_reason_r;
  logic signed [TS_W-1:0] res_pts_nxt;
  logic [REASON_W-1:0]   res_reason_nxt;

  // Output register.
  logic                  out_valid_r;
  logic signed [TS_W-1:0] out_pts_r;
  logic                  out_drop_r;
  logic [REASON_W-1:0]   out_reason_r;
  logic [LAT_W-1:0]      out_avg_r;
  logic [COUNT_W-1:0]    out_count_r;
  ctr_t                  out_drift_r;
  ctr_t                  out_comp_r;
  ctr_t                  out_queue_r;

  logic                  in_fire;
  logic                  out_fire;
  logic                  out_load;
  logic                  full;
  logic                  do_sample;
  logic signed [TS_W:0]  comp_diff;
  logic signed [TS_W-1:0] comp_pts;
  logic signed [TS_W:0]  drift;
  logic                  drift_hit;
  logic                  queue_hit;
  logic [SLOT_W-1:0]     slot_inc;
  logic                  div_go_r;
  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      div_quo;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_valid_r && out_ch.ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign full      = fill_r == CNT_W'(WINDOW);
  assign do_sample = (state_r == ST_UPD) && (func_r == FUNC_SAMPLE);
  assign slot_inc  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);

  // The divider start is registered from the window update, so that it takes
  // the new running sum and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= do_sample;
    end
  end

  assign div_start = div_go_r;

  // Compensation: the subtraction can only run past the negative end, so a
  // sign overflow in the 49-bit difference means clamp to the minimum.
  assign comp_diff = {pts_r[TS_W-1], pts_r} - $signed({{(TS_W+1-LAT_W){1'b0}}, avg_r});
  assign comp_pts  = (comp_diff < MIN48_X) ? MIN48_X[TS_W-1:0] : comp_diff[TS_W-1:0];

  // Drift is exact in 49 bits and compared strictly against the threshold.
  assign drift     = {master_r[TS_W-1], master_r} - {pts_r[TS_W-1], pts_r};
  assign drift_hit = clk_present_r &&
                     (drift > $signed({{(TS_W+1-THR_W){1'b0}}, thr_r}));
  assign queue_hit = (cap_r != '0) && (depth_r >= cap_r);

  // Result fields of the latched request. The queue-full drop wins over the
  // drift drop in an aggressive check.
  assign res_pts_nxt = ((func_r == FUNC_COMP_COUNT) || (func_r == FUNC_COMP_VALUE)) ?
                       comp_pts : pts_r;

  always_comb begin
    priority if ((func_r == FUNC_AGGRESSIVE) && queue_hit) begin
      res_reason_nxt = REASON_QUEUE;
    end else if (((func_r == FUNC_DRIFT) || (func_r == FUNC_AGGRESSIVE)) && drift_hit) begin
      res_reason_nxt = REASON_DRIFT;
    end else begin
      res_reason_nxt = REASON_NONE;
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r         <= THRESHOLD_RESET;
      clk_present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DROP_THRESHOLD: thr_r         <= cfg_data[THR_W-1:0];
        REG_CLOCK_PRESENT:  clk_present_r <= cfg_data[0];
      endcase
    end
  end

  // The ring is read every cycle at the current slot; the value read at the
  // accept edge is the oldest sample when the window is full.
  always_ff @(posedge clk) begin
    rd_data_r <= ring_mem[slot_r];
    if (do_sample) begin
      ring_mem[slot_r] <= lat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_ch.func;
      lat_r    <= in_ch.latency_us;
      pts_r    <= in_ch.pts_us;
      master_r <= in_ch.master_clock_us;
      depth_r  <= in_ch.queue_depth;
      cap_r    <= in_ch.queue_capacity;
    end
  end

  // Sequencer and window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      drift_ctr_r <= '0;
      comp_ctr_r  <= '0;
      queue_ctr_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          res_pts_r    <= res_pts_nxt;
          res_drop_r   <= (res_reason_nxt != REASON_NONE);
          res_reason_r <= res_reason_nxt;
          state_r      <= (func_r == FUNC_SAMPLE) ? ST_DIV : ST_DONE;
          unique case (func_r)
            FUNC_SAMPLE: begin
              if (full) begin
                sum_r <= sum_r - SUM_W'(rd_data_r) + SUM_W'(lat_r);
              end else begin
                sum_r  <= sum_r + SUM_W'(lat_r);
                fill_r <= fill_r + CNT_W'(1);
              end
              slot_r <= slot_inc;
            end
            FUNC_COMP_COUNT: begin
              comp_ctr_r <= sat_inc(comp_ctr_r);
            end
            FUNC_COMP_VALUE: begin
              // A plain compensation moves no counter.
            end
            FUNC_DRIFT: begin
              if (drift_hit) begin
                drift_ctr_r <= sat_inc(drift_ctr_r);
              end
            end
            FUNC_AGGRESSIVE: begin
              priority if (queue_hit) begin
                queue_ctr_r <= sat_inc(queue_ctr_r);
              end else if (drift_hit) begin
                drift_ctr_r <= sat_inc(drift_ctr_r);
              end else begin
                // Neither check fires, so the counters hold.
              end
            end
            FUNC_CLEAR: begin
              slot_r      <= '0;
              fill_r      <= '0;
              sum_r       <= '0;
              avg_r       <= '0;
              drift_ctr_r <= '0;
              comp_ctr_r  <= '0;
              queue_ctr_r <= '0;
            end
            default: begin
              // Unused codes leave every piece of state alone.
            end
          endcase
        end
        ST_DIV: begin
          // The window holds at least one sample here, so the divisor is
          // never zero and the quotient never exceeds the largest sample.
          if (div_done) begin
            avg_r   <= div_quo[LAT_W-1:0];
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  lwpc_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_lwpc_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (fill_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pts_r    <= res_pts_r;
      out_drop_r   <= res_drop_r;
      out_reason_r <= res_reason_r;
      out_avg_r    <= avg_r;
      out_count_r  <= COUNT_W'(fill_r);
      out_drift_r  <= drift_ctr_r;
      out_comp_r   <= comp_ctr_r;
      out_queue_r  <= queue_ctr_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.result_pts_us      = out_pts_r;
  assign out_ch.drop               = out_drop_r;
  assign out_ch.drop_reason        = out_reason_r;
  assign out_ch.average_latency_us = out_avg_r;
  assign out_ch.sample_count       = out_count_r;
  assign out_ch.dropped_total      = out_drift_r;
  assign out_ch.compensated_total  = out_comp_r;
  assign out_ch.aggressive_total   = out_queue_r;

endmodule
`default_nettype wire

// ----- src/lwpc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module lwpc_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W:0]    trial_sub;

  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- src/lwpc_checker.sv -----
// Port-level assertions for the compensator, bound to its top level.
`default_nettype none
module lwpc_checker #(
  parameter int WINDOW = lwpc_pkg::DEF_WINDOW
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [lwpc_pkg::TS_W-1:0] out_pts,
  input wire logic                          out_drop,
  input wire logic [lwpc_pkg::REASON_W-1:0] out_reason,
  input wire logic [lwpc_pkg::LAT_W-1:0]    out_avg,
  input wire logic [lwpc_pkg::COUNT_W-1:0]  out_count
);
  import lwpc_pkg::*;

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pts) && $stable(out_count))
    else $error("stalled result changed");

  // The drop flag and the drop reason agree.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drop == (out_reason != REASON_NONE)))
    else $error("drop flag and reason disagree");

  // The window never reports more samples than it can hold, and an empty
  // window reports a zero average.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= COUNT_W'(WINDOW)))
    else $error("sample count above window size");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_count == '0) |-> (out_avg == '0))
    else $error("nonzero average with empty window");

  // No result is pending right after reset.
  assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind latency_window_pts_compensator_core lwpc_checker #(
  .WINDOW (WINDOW)
) u_lwpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_pts    (out_ch.result_pts_us),
  .out_drop   (out_ch.drop),
  .out_reason (out_ch.drop_reason),
  .out_avg    (out_ch.average_latency_us),
  .out_count  (out_ch.sample_count)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the latency window PTS compensator core.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lwpc_pkg::*;

  localparam int WINDOW = DEF_WINDOW;

  // Codes 6 and 7 are not operations.
  // The block must leave its state alone and report the current values.
  localparam logic [FUNC_W-1:0] FUNC_UNDEF_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNDEF_B = 3'd7;

  localparam logic [TS_W-1:0] TS_MIN = {1'b1, {(TS_W-1){1'b0}}};
  localparam logic [TS_W-1:0] TS_MAX = {1'b0, {(TS_W-1){1'b1}}};
  localparam logic [LAT_W-1:0] LAT_MAX = '1;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  // A latency sample keeps the core busy longest, through its divide. After the last
  // result, this many quiet cycles also show any stray result.
  localparam int SETTLE_CYCLES = 48;
  // The receiver holds off this long when the stimulus asks for backpressure.
  localparam int LONG_STALL    = 300;
  // The longest correct stretch with no handshake on either channel is the
  // long hold-off plus one sample and a phase change. The limit is set above that.
  localparam int IDLE_LIMIT    = 4000;
  localparam int MAX_PRINTED   = 30;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [LAT_W-1:0]   lat;
    logic [TS_W-1:0]    pts;
    logic [TS_W-1:0]    master;
    logic [QUEUE_W-1:0] depth;
    logic [QUEUE_W-1:0] cap;
  } frame_req_t;

  typedef struct {
    logic [TS_W-1:0]     pts;
    logic                drop;
    logic [REASON_W-1:0] reason;
    logic [LAT_W-1:0]    avg;
    logic [COUNT_W-1:0]  count;
    logic [CTR_W-1:0]    drift_drops;
    logic [CTR_W-1:0]    counted_comps;
    logic [CTR_W-1:0]    queue_drops;
  } frame_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;

  lwpc_in_if  in_ch ();
  lwpc_out_if out_ch ();

  latency_window_pts_compensator_core #(.WINDOW(WINDOW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests still to be offered, and the results predicted for the accepted ones.
  frame_req_t request_backlog[$];
  frame_res_t predicted_results[$];

  // Our own copy of the latency window, the counters and the two registers.
  logic [LAT_W-1:0] win_lat [WINDOW];
  int unsigned      win_slot;
  int unsigned      win_fill;
  logic [28:0]      win_sum;
  logic [CTR_W-1:0] drift_drops;
  logic [CTR_W-1:0] counted_comps;
  logic [CTR_W-1:0] queue_drops;
  logic [THR_W-1:0] thr_us;
  logic             clk_attached;

  // Counts used for the closing summary and the verdict.
  int mismatches;
  int results_checked;
  int func_seen [8];
  int saturated_pts;
  int window_wraps;
  int drift_drops_seen;
  int queue_drops_seen;

  // State of the driver and the receiver.
  int gap_left;
  int burst_left;
  int stall_asks;
  int stalls_served;
  int stall_left;
  int mode_left;
  int ready_mode;
  logic [7:0] ready_mask;
  int idle_cycles;

  function automatic logic [CTR_W-1:0] saturating_bump(input logic [CTR_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [LAT_W-1:0] window_mean();
    if (win_fill == 0) return '0;
    return LAT_W'(win_sum / win_fill);
  endfunction

  // Append a request to the backlog, and take the oldest one out of it.
  task automatic add_request(input frame_req_t r);
    request_backlog.insert(request_backlog.size(), r);
  endtask

  function automatic frame_req_t take_next_request();
    frame_req_t r;
    r = request_backlog[0];
    request_backlog.delete(0);
    return r;
  endfunction

  // A drift drop needs the clock attached and master minus pts strictly above
  // the threshold. The difference is taken exactly, on 49 bits.
  function automatic logic drift_exceeded(input logic [TS_W-1:0] master,
                                          input logic [TS_W-1:0] pts);
    logic [TS_W:0] diff;
    diff = {master[TS_W-1], master} - {pts[TS_W-1], pts};
    return clk_attached && !diff[TS_W] && (diff[TS_W-1:0] > {24'd0, thr_us});
  endfunction

  // Apply one accepted request to the model and queue the result that it gives.
  task automatic predict_frame_result(input frame_req_t r);
    frame_res_t res;
    logic [TS_W:0] comp;
    res.pts    = r.pts;
    res.drop   = 1'b0;
    res.reason = REASON_NONE;
    func_seen[r.func]++;
    case (r.func)
      FUNC_SAMPLE: begin
        if (win_fill == WINDOW) begin
          // The oldest sample leaves the running sum.
          win_sum = win_sum - win_lat[win_slot];
          window_wraps++;
        end else begin
          win_fill++;
        end
        win_lat[win_slot] = r.lat;
        win_sum  = win_sum + r.lat;
        win_slot = (win_slot + 1) % WINDOW;
      end
      FUNC_COMP_COUNT, FUNC_COMP_VALUE: begin
        comp = {r.pts[TS_W-1], r.pts} - {25'd0, window_mean()};
        // Only an underflow is possible, since the average is never negative.
        if (comp[TS_W] != comp[TS_W-1]) begin
          res.pts = TS_MIN;
          saturated_pts++;
        end else begin
          res.pts = comp[TS_W-1:0];
        end
        if (r.func == FUNC_COMP_COUNT) counted_comps = saturating_bump(counted_comps);
      end
      FUNC_DRIFT: begin
        if (drift_exceeded(r.master, r.pts)) begin
          drift_drops = saturating_bump(drift_drops);
          res.drop    = 1'b1;
          res.reason  = REASON_DRIFT;
        end
      end
      FUNC_AGGRESSIVE: begin
        // A full queue wins over drift. A zero capacity turns the queue test off.
        if (r.cap != 0 && r.depth >= r.cap) begin
          queue_drops = saturating_bump(queue_drops);
          res.drop    = 1'b1;
          res.reason  = REASON_QUEUE;
        end else if (drift_exceeded(r.master, r.pts)) begin
          drift_drops = saturating_bump(drift_drops);
          res.drop    = 1'b1;
          res.reason  = REASON_DRIFT;
        end
      end
      FUNC_CLEAR: begin
        // The window and all counters are cleared. The registers keep their values.
        foreach (win_lat[i]) win_lat[i] = '0;
        win_slot      = 0;
        win_fill      = 0;
        win_sum       = '0;
        drift_drops   = '0;
        counted_comps = '0;
        queue_drops   = '0;
      end
      default: begin
      end
    endcase
    if (res.reason == REASON_DRIFT) drift_drops_seen++;
    if (res.reason == REASON_QUEUE) queue_drops_seen++;
    res.avg           = window_mean();
    res.count         = COUNT_W'(win_fill);
    res.drift_drops   = drift_drops;
    res.counted_comps = counted_comps;
    res.queue_drops   = queue_drops;
    predicted_results.insert(predicted_results.size(), res);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               results_checked, field, got, want);
  endtask

  function automatic frame_req_t frame_request(input logic [FUNC_W-1:0] func,
                                               input logic [LAT_W-1:0] lat,
                                               input logic [TS_W-1:0] pts,
                                               input logic [TS_W-1:0] master,
                                               input logic [QUEUE_W-1:0] depth,
                                               input logic [QUEUE_W-1:0] cap);
    frame_req_t r;
    r.func   = func;
    r.lat    = lat;
    r.pts    = pts;
    r.master = master;
    r.depth  = depth;
    r.cap    = cap;
    return r;
  endfunction

  // Most random requests are real traffic: many samples, so that the window
  // fills and wraps, and drift and queue checks aimed near their thresholds.
  // The rest are timestamps across the whole range, undefined codes and clears.
  function automatic frame_req_t make_random_request();
    frame_req_t r;
    int pick;
    logic [63:0] wide;
    pick = $urandom_range(0, 99);
    if (pick < 40)       r.func = FUNC_SAMPLE;
    else if (pick < 55)  r.func = FUNC_COMP_COUNT;
    else if (pick < 65)  r.func = FUNC_COMP_VALUE;
    else if (pick < 80)  r.func = FUNC_DRIFT;
    else if (pick < 96)  r.func = FUNC_AGGRESSIVE;
    else if (pick == 96) r.func = FUNC_CLEAR;
    else                 r.func = FUNC_W'($urandom_range(0, 7));

    r.lat = ($urandom_range(0, 1) != 0) ? LAT_W'($urandom()) : LAT_W'($urandom_range(0, 5000));

    wide = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 60)      r.pts = {{16{wide[31]}}, wide[31:0]};
    else if (pick < 85) r.pts = wide[TS_W-1:0];
    else                r.pts = TS_MIN + TS_W'($urandom_range(0, 20000));

    wide = {$urandom(), $urandom()};
    if ($urandom_range(0, 9) < 7)
      r.master = r.pts + {24'd0, thr_us} + TS_W'($urandom_range(0, 6)) - TS_W'(3);
    else
      r.master = wide[TS_W-1:0];

    pick = $urandom_range(0, 9);
    if (pick < 2)      r.cap = '0;
    else if (pick < 4) r.cap = QUEUE_W'($urandom());
    else               r.cap = QUEUE_W'($urandom_range(1, 64));
    if ($urandom_range(0, 9) < 6)
      r.depth = r.cap + QUEUE_W'($urandom_range(0, 4)) - QUEUE_W'(2);
    else
      r.depth = QUEUE_W'($urandom());
    return r;
  endfunction

  task automatic queue_random_requests(input int n);
    for (int i = 0; i < n; i++) add_request(make_random_request());
  endtask

  // The core is written only while it is idle, so the model takes the new value
  // right away.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == REG_DROP_THRESHOLD) thr_us = data[THR_W-1:0];
    else clk_attached = data[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The sender pauses until every request has been taken and every predicted
  // result has come back, then lets the core go quiet.
  task automatic settle_until_idle();
    while (request_backlog.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver. It works in bursts of random length separated by random gaps.
  // Some gaps are long enough to fall on any cycle of a sample's divide.
  // An offered request stays on the bus unchanged until the core takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    = 0;
      burst_left  = $urandom_range(1, 12);
    end else begin
      if (in_ch.valid && in_ch.ready) predict_frame_result(take_next_request());
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          in_ch.valid           <= 1'b1;
          in_ch.func            <= request_backlog[0].func;
          in_ch.latency_us      <= request_backlog[0].lat;
          in_ch.pts_us          <= request_backlog[0].pts;
          in_ch.master_clock_us <= request_backlog[0].master;
          in_ch.queue_depth     <= request_backlog[0].depth;
          in_ch.queue_capacity  <= request_backlog[0].cap;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: gap_left = 0;
              5, 6, 7:       gap_left = $urandom_range(1, 5);
              default:       gap_left = $urandom_range(6, 40);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker. Every so often it picks a new way to stall:
  // always ready, mostly ready, mostly stalled, or a rotating bit mask. When
  // the stimulus asks for it, it starts a long hold-off. The sender
  // keeps offering requests meanwhile, so the core fills up and lowers its ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      stalls_served = 0;
      stall_left    = 0;
      mode_left     = 0;
      ready_mode    = 0;
      ready_mask    = 8'hff;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_ch.result_pts_us, 0);
        end else begin
          frame_res_t want;
          want = predicted_results[0];
          predicted_results.delete(0);
          if (out_ch.result_pts_us !== want.pts)
            report_mismatch("result_pts_us", out_ch.result_pts_us, want.pts);
          if (out_ch.drop !== want.drop)
            report_mismatch("drop", out_ch.drop, want.drop);
          if (out_ch.drop_reason !== want.reason)
            report_mismatch("drop_reason", out_ch.drop_reason, want.reason);
          if (out_ch.average_latency_us !== want.avg)
            report_mismatch("average_latency_us", out_ch.average_latency_us, want.avg);
          if (out_ch.sample_count !== want.count)
            report_mismatch("sample_count", out_ch.sample_count, want.count);
          if (out_ch.dropped_total !== want.drift_drops)
            report_mismatch("dropped_total", out_ch.dropped_total, want.drift_drops);
          if (out_ch.compensated_total !== want.counted_comps)
            report_mismatch("compensated_total", out_ch.compensated_total, want.counted_comps);
          if (out_ch.aggressive_total !== want.queue_drops)
            report_mismatch("aggressive_total", out_ch.aggressive_total, want.queue_drops);
          results_checked++;
        end
      end

      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 96);
        ready_mask = 8'($urandom()) | 8'h01;
      end else begin
        mode_left--;
      end

      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_asks > stalls_served) begin
        stalls_served++;
        stall_left = LONG_STALL - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_ch.ready <= ready_mask[0];
            ready_mask = {ready_mask[0], ready_mask[7:1]};
          end
        endcase
      end
    end
  end

  // The watchdog ends a run in which neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    // Every input is known from time zero, and the model starts in its reset state.
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.func            = FUNC_SAMPLE;
    in_ch.latency_us      = '0;
    in_ch.pts_us          = '0;
    in_ch.master_clock_us = '0;
    in_ch.queue_depth     = '0;
    in_ch.queue_capacity  = '0;
    out_ch.ready          = 1'b0;
    foreach (win_lat[i]) win_lat[i] = '0;
    win_slot      = 0;
    win_fill      = 0;
    win_sum       = '0;
    drift_drops   = '0;
    counted_comps = '0;
    queue_drops   = '0;
    thr_us        = THRESHOLD_RESET;
    clk_attached  = 1'b0;
    mismatches    = 0;
    results_checked = 0;
    foreach (func_seen[i]) func_seen[i] = 0;
    saturated_pts    = 0;
    window_wraps     = 0;
    drift_drops_seen = 0;
    queue_drops_seen = 0;
    stall_asks       = 0;
    idle_cycles      = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no clock is attached, so drift never drops a frame.
    // Compensation of an empty window gives the pts unchanged, even at its minimum.
    add_request(frame_request(FUNC_COMP_VALUE, '0, TS_MIN, '0, '0, '0));
    add_request(frame_request(FUNC_COMP_COUNT, '0, TS_MAX, '0, '0, '0));
    add_request(frame_request(FUNC_DRIFT, '0, TS_MIN, TS_MAX, '0, '0));
    // A zero capacity never counts as full. A capacity that is exactly reached does.
    add_request(frame_request(FUNC_AGGRESSIVE, '0, '0, TS_MAX, '1, '0));
    add_request(frame_request(FUNC_AGGRESSIVE, '0, '0, '0, '1, '1));
    add_request(frame_request(FUNC_AGGRESSIVE, '0, '0, '0, 16'd9, 16'd10));
    add_request(frame_request(FUNC_SAMPLE, LAT_MAX, '0, '0, '0, '0));
    add_request(frame_request(FUNC_SAMPLE, '0, '0, '0, '0, '0));
    add_request(frame_request(FUNC_SAMPLE, 24'd1, '0, '0, '0, '0));
    // A nonzero average pushes a timestamp near the minimum below the range,
    // so the result saturates.
    add_request(frame_request(FUNC_COMP_VALUE, '0, TS_MIN, '0, '0, '0));
    add_request(frame_request(FUNC_COMP_COUNT, '0, TS_MIN + 48'd5, '0, '0, '0));
    add_request(frame_request(FUNC_UNDEF_A, LAT_MAX, TS_MAX, TS_MIN, '1, '1));
    add_request(frame_request(FUNC_UNDEF_B, LAT_MAX, TS_MIN, TS_MAX, '1, '1));
    add_request(frame_request(FUNC_CLEAR, LAT_MAX, TS_MAX, TS_MAX, '1, '1));
    add_request(frame_request(FUNC_COMP_VALUE, '0, 48'd12345, '0, '0, '0));
    settle_until_idle();

    // With a zero threshold, a drift of one drops the frame and a drift of zero does not.
    write_register(REG_DROP_THRESHOLD, '0);
    write_register(REG_CLOCK_PRESENT, 24'd1);
    add_request(frame_request(FUNC_DRIFT, '0, '0, 48'd1, '0, '0));
    add_request(frame_request(FUNC_DRIFT, '0, '0, '0, '0, '0));
    add_request(frame_request(FUNC_AGGRESSIVE, '0, '0, TS_MAX, 16'd1, 16'd1));
    add_request(frame_request(FUNC_AGGRESSIVE, '0, '0, 48'd5, 16'd7, '0));
    settle_until_idle();

    // Largest threshold, and drifts that span the full 49-bit range either way.
    write_register(REG_DROP_THRESHOLD, THR_MAX);
    add_request(frame_request(FUNC_DRIFT, '0, '0, 48'hFFFFFF, '0, '0));
    add_request(frame_request(FUNC_DRIFT, '0, '0, 48'h1000000, '0, '0));
    add_request(frame_request(FUNC_DRIFT, '0, TS_MIN, TS_MAX, '0, '0));
    add_request(frame_request(FUNC_DRIFT, '0, TS_MAX, TS_MIN, '0, '0));
    add_request(frame_request(FUNC_AGGRESSIVE, '0, '0, 48'h1000000, 16'd3, 16'd4));
    settle_until_idle();

    // Random traffic under several settings. Two phases begin with a long
    // hold-off at the receiver while requests keep coming.
    write_register(REG_DROP_THRESHOLD, THRESHOLD_RESET);
    queue_random_requests(150);
    settle_until_idle();

    write_register(REG_DROP_THRESHOLD, CFG_DAT_W'($urandom()));
    stall_asks++;
    queue_random_requests(150);
    settle_until_idle();

    write_register(REG_DROP_THRESHOLD, '0);
    write_register(REG_CLOCK_PRESENT, '0);
    queue_random_requests(100);
    settle_until_idle();

    write_register(REG_DROP_THRESHOLD, THR_MAX);
    write_register(REG_CLOCK_PRESENT, 24'd1);
    stall_asks++;
    queue_random_requests(150);
    settle_until_idle();

    write_register(REG_DROP_THRESHOLD, CFG_DAT_W'($urandom_range(0, 2000)));
    queue_random_requests(150);
    settle_until_idle();

    $display("covered %0d samples (%0d wraps), %0d+%0d compensations (%0d saturated)",
             func_seen[FUNC_SAMPLE], window_wraps, func_seen[FUNC_COMP_COUNT],
             func_seen[FUNC_COMP_VALUE], saturated_pts);
    $display("%0d drift/%0d queue checks, %0d/%0d drops, %0d clears, %0d undef, %0d results",
             func_seen[FUNC_DRIFT], func_seen[FUNC_AGGRESSIVE], drift_drops_seen,
             queue_drops_seen, func_seen[FUNC_CLEAR],
             func_seen[FUNC_UNDEF_A] + func_seen[FUNC_UNDEF_B], results_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
